/* hdl/occupancy_grid_point_update_top_assert.svh */
// Assertion macros for the occupancy grid point update block.
`ifndef OCCUPANCY_GRID_POINT_UPDATE_TOP_ASSERT_SVH
`define OCCUPANCY_GRID_POINT_UPDATE_TOP_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define OGPU_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked at every clock edge out of reset.
`define OGPU_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/ogpu_pkg.sv */
// Shared types, codes and the height exp table of the occupancy grid point update block.
package ogpu_pkg;

    localparam int COORD_W = 24;
    localparam int CSIZE_W = 16;
    localparam int CFG_W   = 24;
    localparam int Q16_W   = 17;

    localparam logic [1:0] CMD_POINT  = 2'd0;
    localparam logic [1:0] CMD_END    = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_CLIPPED = 3'd1;
    localparam logic [2:0] ST_OUTSIDE = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    localparam logic [2:0] CFG_CELL_SIZE = 3'd0;
    localparam logic [2:0] CFG_CLIP_MIN  = 3'd1;
    localparam logic [2:0] CFG_CLIP_MAX  = 3'd2;
    localparam logic [2:0] CFG_NRM_WGT   = 3'd3;
    localparam logic [2:0] CFG_SCORE_THR = 3'd4;
    localparam logic [2:0] CFG_OCC_THR   = 3'd5;
    localparam logic [2:0] CFG_ACC_MODE  = 3'd6;

    localparam logic signed [7:0] VAL_UNSEEN = -8'sd1;
    localparam logic signed [7:0] VAL_FREE   = 8'sd0;
    localparam logic signed [7:0] VAL_OCC    = 8'sd100;

    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [65:0] EXP_STEP_Q32 = 66'd4162825044;

    typedef logic [16:0] t_exp_tab [256];

    // exp(-i/32) in Q1.16, built by the fixed-point recurrence
    function automatic t_exp_tab exp_tab_build();
        t_exp_tab   tab;
        logic [65:0] e;
        e = 66'd1 << 32;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 17'((e + 66'd32768) >> 16);
            e = (e * EXP_STEP_Q32 + (66'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = exp_tab_build();

endpackage

/* hdl/ogpu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ogpu_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ogpu_div.sv */
// Bit-serial restoring divider: 24-bit magnitude by 16-bit cell size, one bit per cycle.
module ogpu_div
    import ogpu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [CSIZE_W-1:0] i_divisor,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(COORD_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [COORD_W-1:0] r_q;
    logic [CSIZE_W-1:0] r_rem;
    logic [CSIZE_W-1:0] r_dvs;

    logic [CSIZE_W:0]   n_trial;
    logic               n_ge;
    logic [CSIZE_W:0]   n_rem;

    always_comb begin
        n_trial = {r_rem, r_q[COORD_W-1]};
        n_ge    = n_trial >= {1'b0, r_dvs};
        n_rem   = n_ge ? n_trial - {1'b0, r_dvs} : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[COORD_W-2:0], n_ge};
            r_rem <= n_rem[CSIZE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hdl/occupancy_grid_point_update_top.sv */
// Occupancy grid point update: clip, score, cell divide and hit-counter store.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+------------------------------------------
//  command  | start, busy (taken: start&!busy)| i_cmd, i_point_*, i_normal_z, i_cell_*
//  result   | o_result_valid (one cycle)      | o_status, o_cell_value, o_cell_count, o_min_*
//  config   | i_cfg_valid, o_cfg_ready        | i_cfg_index, i_cfg_data
//
// A point that reaches the store goes through S_DIV, which waits on the bit-serial 24-bit division
// by cell size, then S_RDA and S_USE; a point outside the grid returns from S_DIV; a cell read
// goes through S_RDA and S_USE; end of cloud, clipped, locked points and unused commands answer from S_IDLE.
// After reset a clearing pass writes all GRID_SIDE*GRID_SIDE cells, one per cycle,
// with busy high. Results cannot be stalled.
`include "occupancy_grid_point_update_top_assert.svh"

module occupancy_grid_point_update_top
    import ogpu_pkg::*;
#(
    parameter int GRID_SIDE = 256,
    parameter int COUNT_MAX = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_cmd,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic signed [15:0]        i_normal_z,
    input  logic [7:0]                i_cell_col,
    input  logic [7:0]                i_cell_row,
    output logic                      o_result_valid,
    output logic [2:0]                o_status,
    output logic signed [7:0]         o_cell_value,
    output logic [3:0]                o_cell_count,
    output logic signed [7:0]         o_min_col,
    output logic signed [7:0]         o_min_row,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int MAW   = $clog2(DEPTH);
    localparam int CNTW  = $clog2(COUNT_MAX + 1);
    localparam int EW    = CNTW + 1;
    localparam int HALF  = GRID_SIDE / 2;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIV, S_RDA, S_USE} t_state;

    t_state r_state;

    logic [CSIZE_W-1:0]        r_cell_size;
    logic signed [COORD_W-1:0] r_clip_min;
    logic signed [COORD_W-1:0] r_clip_max;
    logic [Q16_W-1:0]          r_nrm_wgt;
    logic [Q16_W-1:0]          r_score_thr;
    logic [3:0]                r_occ_thr;
    logic                      r_acc_mode;

    logic                      r_lock;
    logic signed [7:0]         r_least_col;
    logic signed [7:0]         r_least_row;
    logic [MAW-1:0]            r_clr;
    logic [MAW-1:0]            r_addr;
    logic                      r_is_read;
    logic                      r_sx;
    logic                      r_sy;
    logic signed [COORD_W:0]   r_gx;
    logic signed [COORD_W:0]   r_gy;
    logic signed [15:0]        r_nz;
    logic signed [COORD_W-1:0] r_pz;
    logic [1:0]                r_sph;
    logic [16:0]               r_flat;
    logic [16:0]               r_height;
    logic [33:0]               r_prod;
    logic [33:0]               r_sum;

    logic                      r_res_valid;
    logic [2:0]                r_res_status;
    logic signed [7:0]         r_res_value;
    logic [3:0]                r_res_count;

    logic                      ram_we;
    logic [MAW-1:0]            ram_waddr;
    logic [EW-1:0]             ram_wdata;
    logic [EW-1:0]             ram_rdata;

    logic                      div_go;
    logic                      x_done;
    logic                      y_done;
    logic [COORD_W-1:0]        x_quot;
    logic [COORD_W-1:0]        y_quot;
    logic [COORD_W-1:0]        n_ax;
    logic [COORD_W-1:0]        n_ay;
    logic [CSIZE_W-1:0]        n_cs;

    logic                      n_locked;
    logic                      n_clipped;
    logic                      n_rd_out;
    logic [MAW-1:0]            n_rd_addr;

    logic [15:0]               n_anz;
    logic [14:0]               n_anz_c;
    logic [16:0]               n_flat;
    logic [COORD_W-1:0]        n_az;
    logic [7:0]                n_idx;
    logic [16:0]               n_height;
    logic [16:0]               n_w;
    logic [16:0]               n_wc;
    logic                      n_hit;

    logic signed [COORD_W:0]   n_gx;
    logic signed [COORD_W:0]   n_gy;
    logic                      n_in_grid;
    logic [MAW-1:0]            n_pt_addr;

    logic                      n_seen;
    logic [CNTW-1:0]           n_cnt_old;
    logic [CNTW-1:0]           n_cnt;
    logic signed [7:0]         n_rd_value;
    logic signed [7:0]         n_up_value;
    logic signed [7:0]         n_lcol;
    logic signed [7:0]         n_lrow;

    always_comb begin
        n_locked  = !r_acc_mode && r_lock;
        n_clipped = (i_point_z > r_clip_max) || (i_point_z < r_clip_min);
        n_rd_out  = (int'(i_cell_col) >= GRID_SIDE) || (int'(i_cell_row) >= GRID_SIDE);
        n_rd_addr = MAW'(int'(i_cell_row) * GRID_SIDE + int'(i_cell_col));
        div_go    = (r_state == S_IDLE) && start && (i_cmd == CMD_POINT)
                    && !n_locked && !n_clipped;
        n_ax      = i_point_x[COORD_W-1] ? COORD_W'(-i_point_x) : COORD_W'(i_point_x);
        n_ay      = i_point_y[COORD_W-1] ? COORD_W'(-i_point_y) : COORD_W'(i_point_y);
        n_cs      = (r_cell_size == '0) ? CSIZE_W'(1) : r_cell_size;

        n_anz    = r_nz[15] ? 16'(-r_nz) : 16'(r_nz);
        n_anz_c  = 15'(16384) - ((n_anz > 16'd16384) ? 15'(16384) : n_anz[14:0]);
        n_flat   = {n_anz_c, 2'b00};
        n_az     = r_pz[COORD_W-1] ? COORD_W'(-r_pz) : COORD_W'(r_pz);
        n_idx    = (n_az[COORD_W-1:13] != '0) ? 8'hFF : n_az[12:5];
        n_height = Q16_ONE - EXP_TAB[n_idx];
        n_w      = (r_nrm_wgt > Q16_ONE) ? Q16_ONE : r_nrm_wgt;
        n_wc     = Q16_ONE - n_w;
        n_hit    = r_sum[33:16] >= 18'(r_score_thr);

        n_gx      = r_sx ? -$signed({1'b0, x_quot}) : $signed({1'b0, x_quot});
        n_gy      = r_sy ? -$signed({1'b0, y_quot}) : $signed({1'b0, y_quot});
        n_in_grid = (n_gx >= -$signed((COORD_W+1)'(HALF)))
                    && (n_gx < $signed((COORD_W+1)'(HALF)))
                    && (n_gy >= -$signed((COORD_W+1)'(HALF)))
                    && (n_gy < $signed((COORD_W+1)'(HALF)));
        n_pt_addr = MAW'((int'(n_gy) + HALF) * GRID_SIDE + (int'(n_gx) + HALF));

        n_seen    = ram_rdata[CNTW];
        n_cnt_old = ram_rdata[CNTW-1:0];
        if (!n_seen) begin
            n_cnt = n_hit ? CNTW'(1) : '0;
        end else if (n_hit) begin
            n_cnt = (n_cnt_old < CNTW'(COUNT_MAX)) ? n_cnt_old + 1'b1 : n_cnt_old;
        end else begin
            n_cnt = (n_cnt_old != '0) ? n_cnt_old - 1'b1 : n_cnt_old;
        end
        n_rd_value = !n_seen ? VAL_UNSEEN
                   : ((9'(n_cnt_old) > 9'(r_occ_thr)) ? VAL_OCC : VAL_FREE);
        n_up_value = (9'(n_cnt) > 9'(r_occ_thr)) ? VAL_OCC : VAL_FREE;

        n_lcol = r_least_col;
        if (r_gx < COORD_W'(r_least_col)) begin
            n_lcol = (r_gx < -(COORD_W+1)'(128)) ? -8'sd128 : 8'(r_gx);
        end
        n_lrow = r_least_row;
        if (r_gy < COORD_W'(r_least_row)) begin
            n_lrow = (r_gy < -(COORD_W+1)'(128)) ? -8'sd128 : 8'(r_gy);
        end

        ram_we    = (r_state == S_CLEAR) || ((r_state == S_USE) && !r_is_read);
        ram_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
        ram_wdata = (r_state == S_CLEAR) ? '0 : {1'b1, n_cnt};
    end

    ogpu_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    ogpu_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (n_ax),
        .i_divisor  (n_cs),
        .o_done     (x_done),
        .o_quot     (x_quot)
    );

    ogpu_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (n_ay),
        .i_divisor  (n_cs),
        .o_done     (y_done),
        .o_quot     (y_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= CSIZE_W'(51);
            r_clip_min  <= -COORD_W'(1024);
            r_clip_max  <= COORD_W'(2048);
            r_nrm_wgt   <= Q16_W'(32768);
            r_score_thr <= Q16_W'(19661);
            r_occ_thr   <= 4'd5;
            r_acc_mode  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CELL_SIZE: r_cell_size <= i_cfg_data[CSIZE_W-1:0];
                CFG_CLIP_MIN:  r_clip_min  <= i_cfg_data;
                CFG_CLIP_MAX:  r_clip_max  <= i_cfg_data;
                CFG_NRM_WGT:   r_nrm_wgt   <= i_cfg_data[Q16_W-1:0];
                CFG_SCORE_THR: r_score_thr <= i_cfg_data[Q16_W-1:0];
                CFG_OCC_THR:   r_occ_thr   <= i_cfg_data[3:0];
                CFG_ACC_MODE:  r_acc_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_lock      <= 1'b0;
            r_least_col <= '0;
            r_least_row <= '0;
            r_res_valid <= 1'b0;
            r_sph       <= '0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == MAW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_res_valid  <= 1'b1;
                        r_res_value  <= VAL_FREE;
                        r_res_count  <= '0;
                        case (i_cmd)
                            CMD_POINT: begin
                                if (n_locked) begin
                                    r_res_status <= ST_IGNORED;
                                end else if (n_clipped) begin
                                    r_res_status <= ST_CLIPPED;
                                end else begin
                                    r_res_valid <= 1'b0;
                                    r_sx        <= i_point_x[COORD_W-1];
                                    r_sy        <= i_point_y[COORD_W-1];
                                    r_nz        <= i_normal_z;
                                    r_pz        <= i_point_z;
                                    r_sph       <= '0;
                                    r_state     <= S_DIV;
                                end
                            end
                            CMD_END: begin
                                if (!r_acc_mode) begin
                                    r_lock <= 1'b1;
                                end
                                r_res_status <= ST_DONE;
                            end
                            CMD_READ: begin
                                if (n_rd_out) begin
                                    r_res_status <= ST_OUTSIDE;
                                    r_res_value  <= VAL_UNSEEN;
                                end else begin
                                    r_res_valid <= 1'b0;
                                    r_addr      <= n_rd_addr;
                                    r_is_read   <= 1'b1;
                                    r_state     <= S_RDA;
                                end
                            end
                            default: r_res_status <= ST_IGNORED;
                        endcase
                    end
                end
                S_DIV: begin
                    case (r_sph)
                        2'd0: begin
                            r_flat   <= n_flat;
                            r_height <= n_height;
                            r_sph    <= 2'd1;
                        end
                        2'd1: begin
                            r_prod <= 34'(n_w) * 34'(r_flat);
                            r_sph  <= 2'd2;
                        end
                        2'd2: begin
                            r_sum <= r_prod + 34'(n_wc) * 34'(r_height) + 34'd32768;
                            r_sph <= 2'd3;
                        end
                        default: ;
                    endcase
                    if (x_done && y_done) begin
                        if (n_in_grid) begin
                            r_addr    <= n_pt_addr;
                            r_gx      <= n_gx;
                            r_gy      <= n_gy;
                            r_is_read <= 1'b0;
                            r_state   <= S_RDA;
                        end else begin
                            r_res_valid  <= 1'b1;
                            r_res_status <= ST_OUTSIDE;
                            r_res_value  <= VAL_FREE;
                            r_res_count  <= '0;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                S_RDA: r_state <= S_USE;
                S_USE: begin
                    r_res_valid <= 1'b1;
                    r_state     <= S_IDLE;
                    if (r_is_read) begin
                        r_res_status <= ST_DONE;
                        r_res_value  <= n_rd_value;
                        r_res_count  <= 4'(n_cnt_old);
                    end else begin
                        r_res_status <= ST_UPDATED;
                        r_res_value  <= n_up_value;
                        r_res_count  <= 4'(n_cnt);
                        r_least_col  <= n_lcol;
                        r_least_row  <= n_lrow;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_valid;
    assign o_status       = r_res_status;
    assign o_cell_value   = r_res_value;
    assign o_cell_count   = r_res_count;
    assign o_min_col      = r_least_col;
    assign o_min_row      = r_least_row;

    `OGPU_CHECK_IMP(a_upd_value, o_result_valid && (o_status == ST_UPDATED), (o_cell_value == VAL_FREE) || (o_cell_value == VAL_OCC), "updated cell reads neither free nor occupied")
    `OGPU_CHECK(a_min_nonpos, (!o_min_col[7] && !o_min_row[7]) ? (o_min_col == 8'sd0 && o_min_row == 8'sd0) : 1'b1, "grid minimum went positive")
    `OGPU_CHECK_IMP(a_wr_seen, ram_we && (r_state == S_USE), ram_wdata[CNTW] && (ram_wdata[CNTW-1:0] <= CNTW'(COUNT_MAX)), "bad cell write-back")

endmodule

/* dv/tb_occupancy_grid_point_update_top.sv */
// Self-checking testbench for the occupancy grid point update block: predicts every result.
`timescale 1ns / 100ps

module tb_occupancy_grid_point_update_top;
    import ogpu_pkg::*;

    localparam int GSIDE   = 256;
    localparam int CNT_MAX = 10;
    localparam int WDOG    = 200000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic signed [15:0] nz;
        logic [7:0]         col;
        logic [7:0]         row;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [7:0] value;
        logic [3:0]        count;
        logic signed [7:0] mcol;
        logic signed [7:0] mrow;
    } res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_cmd = '0;
    logic signed [23:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic signed [15:0] i_normal_z = '0;
    logic [7:0] i_cell_col = '0, i_cell_row = '0;
    logic o_result_valid;
    logic [2:0] o_status;
    logic signed [7:0] o_cell_value, o_min_col, o_min_row;
    logic [3:0] o_cell_count;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    occupancy_grid_point_update_top dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic        seen_q [GSIDE*GSIDE];
    logic [3:0]  cnt_q [GSIDE*GSIDE];
    logic        lock_q;
    int          least_c, least_r;
    logic [15:0] cell_size_r;
    logic signed [23:0] clip_lo_r, clip_hi_r;
    logic [16:0] nweight_r, score_thr_r;
    logic [3:0]  occ_thr_r;
    logic        accum_r;

    cmd_t pending_cmds [$];
    res_t expected_res [$];
    int   errors = 0;
    int   idle_pct = 0;
    int   quiet_cycles = 0;
    int   n_points = 0, n_updates = 0, n_reads = 0;
    logic feed_en = 1'b0;

    function automatic int div_trunc(int v, int cs);
        int q;
        q = (v < 0 ? -v : v) / cs;
        return v < 0 ? -q : q;
    endfunction

    function automatic logic signed [7:0] cell_read_val(logic s, logic [3:0] c);
        if (!s) return VAL_UNSEEN;
        return (c > occ_thr_r) ? VAL_OCC : VAL_FREE;
    endfunction

    function automatic res_t grid_update(cmd_t c);
        res_t r;
        int cs, gx, gy, cl, rw, k, anz, az, idx;
        longint flat, hgt, w, score;
        r = '0;
        if (c.cmd == CMD_END) begin
            if (!accum_r) lock_q = 1'b1;
            r.status = ST_DONE;
        end else if (c.cmd == CMD_READ) begin
            k = c.row * GSIDE + c.col;
            r.status = ST_DONE;
            r.value = cell_read_val(seen_q[k], cnt_q[k]);
            r.count = cnt_q[k];
        end else if (c.cmd != CMD_POINT || (!accum_r && lock_q)) begin
            r.status = ST_IGNORED;
        end else if (c.pz > clip_hi_r || c.pz < clip_lo_r) begin
            r.status = ST_CLIPPED;
        end else begin
            cs = (cell_size_r == 0) ? 1 : int'(cell_size_r);
            gx = div_trunc(int'(c.px), cs);
            gy = div_trunc(int'(c.py), cs);
            cl = gx + GSIDE/2;
            rw = gy + GSIDE/2;
            if (cl < 0 || cl >= GSIDE || rw < 0 || rw >= GSIDE) begin
                r.status = ST_OUTSIDE;
            end else begin
                anz = c.nz < 0 ? -int'(c.nz) : int'(c.nz);
                if (anz > 16384) anz = 16384;
                flat = longint'(16384 - anz) * 4;
                az = c.pz < 0 ? -int'(c.pz) : int'(c.pz);
                idx = az >> 5;
                if (idx > 255) idx = 255;
                hgt = 65536 - longint'(EXP_TAB[idx]);
                w = nweight_r > 65536 ? 65536 : longint'(nweight_r);
                score = (w * flat + (65536 - w) * hgt + 32768) >>> 16;
                k = rw * GSIDE + cl;
                if (!seen_q[k]) begin
                    seen_q[k] = 1'b1;
                    cnt_q[k] = (score >= score_thr_r) ? 4'd1 : 4'd0;
                end else if (score >= score_thr_r) begin
                    if (cnt_q[k] < CNT_MAX) cnt_q[k]++;
                end else if (cnt_q[k] > 0) begin
                    cnt_q[k]--;
                end
                if (gx < least_c) least_c = gx < -128 ? -128 : gx;
                if (gy < least_r) least_r = gy < -128 ? -128 : gy;
                r.status = ST_UPDATED;
                r.value = cell_read_val(1'b1, cnt_q[k]);
                r.count = cnt_q[k];
                n_updates++;
            end
        end
        r.mcol = 8'(least_c);
        r.mrow = 8'(least_r);
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (start && !busy) begin
            expected_res.push_back(grid_update({i_cmd, i_point_x, i_point_y, i_point_z,
                                                i_normal_z, i_cell_col, i_cell_row}));
        end
        if (!start || !busy) begin
            if (feed_en && pending_cmds.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                cmd_t c;
                c = pending_cmds.pop_front();
                start      <= 1'b1;
                i_cmd      <= c.cmd;
                i_point_x  <= c.px;
                i_point_y  <= c.py;
                i_point_z  <= c.pz;
                i_normal_z <= c.nz;
                i_cell_col <= c.col;
                i_cell_row <= c.row;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_res.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                res_t e;
                e = expected_res.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_cell_value !== e.value) begin
                    $error("cell_value exp %0d got %0d", e.value, o_cell_value); errors++;
                end
                if (o_cell_count !== e.count) begin
                    $error("cell_count exp %0d got %0d", e.count, o_cell_count); errors++;
                end
                if (o_min_col !== e.mcol) begin
                    $error("min_col exp %0d got %0d", e.mcol, o_min_col); errors++;
                end
                if (o_min_row !== e.mrow) begin
                    $error("min_row exp %0d got %0d", e.mrow, o_min_row); errors++;
                end
            end
        end
    end

    // watchdog, long enough to outlast the clearing pass after reset
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic set_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CELL_SIZE: cell_size_r = val[15:0];
            CFG_CLIP_MIN:  clip_lo_r   = val;
            CFG_CLIP_MAX:  clip_hi_r   = val;
            CFG_NRM_WGT:   nweight_r   = val[16:0];
            CFG_SCORE_THR: score_thr_r = val[16:0];
            CFG_OCC_THR:   occ_thr_r   = val[3:0];
            CFG_ACC_MODE:  accum_r     = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        feed_en = 1'b1;
        wait (pending_cmds.size() == 0);
        @(posedge i_clk);
        while (start || busy || expected_res.size() > 0) @(posedge i_clk);
        feed_en = 1'b0;
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push_cmd(logic [1:0] op, int x, int y, int z, int n, int c, int r);
        pending_cmds.push_back({op, 24'(x), 24'(y), 24'(z), 16'(n), 8'(c), 8'(r)});
        if (op == CMD_POINT) n_points++;
        if (op == CMD_READ) n_reads++;
    endtask

    // mostly points within +-spread, some far off, some reads, cloud ends and unused commands
    task automatic push_random(int n, int spread);
        int sel;
        repeat (n) begin
            sel = $urandom_range(99, 0);
            if (sel < 65)
                push_cmd(CMD_POINT, $signed($urandom_range(2*spread, 0)) - spread,
                         $signed($urandom_range(2*spread, 0)) - spread,
                         $signed($urandom_range(4000, 0)) - 1500,
                         $signed($urandom_range(32768, 0)) - 16384, 0, 0);
            else if (sel < 72)
                push_cmd(CMD_POINT, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            else if (sel < 92)
                push_cmd(CMD_READ, 0, 0, 0, 0, $urandom_range(255, 0),
                         $urandom_range(255, 0));
            else if (sel < 97)
                push_cmd(CMD_END, $urandom, $urandom, $urandom, $urandom, 0, 0);
            else
                push_cmd(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
        end
    endtask

    initial begin
        for (int k = 0; k < GSIDE*GSIDE; k++) begin
            seen_q[k] = 1'b0;
            cnt_q[k] = '0;
        end
        lock_q = 1'b0; least_c = 0; least_r = 0;
        cell_size_r = 16'd51; clip_lo_r = -24'sd1024; clip_hi_r = 24'sd2048;
        nweight_r = 17'd32768; score_thr_r = 17'd19661; occ_thr_r = 4'd5; accum_r = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every command, the special cases
        push_cmd(CMD_READ, 0, 0, 0, 0, 128, 128);
        push_cmd(CMD_POINT, 0, 0, 0, 0, 0, 0);
        push_cmd(CMD_POINT, 0, 0, 0, 16384, 0, 0);
        push_cmd(CMD_POINT, 0, 0, 0, -16384, 0, 0);
        push_cmd(CMD_POINT, 100, -100, 2048, -32768, 0, 0);
        push_cmd(CMD_POINT, 100, -100, -1024, 32767, 0, 0);
        push_cmd(CMD_POINT, 0, 0, 2049, 0, 0, 0);
        push_cmd(CMD_POINT, 0, 0, -1025, 0, 0, 0);
        push_cmd(CMD_POINT, 8388607, 0, 0, 0, 0, 0);
        push_cmd(CMD_POINT, 0, -8388608, 0, 0, 0, 0);
        push_cmd(CMD_POINT, -127*51, -128*51, 500, 0, 0, 0);
        push_cmd(CMD_POINT, 127*51+50, 127*51+50, 0, 0, 0, 0);
        push_cmd(CMD_POINT, -129*51, 0, 0, 0, 0, 0);
        push_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);
        push_cmd(CMD_READ, 0, 0, 0, 0, 255, 255);
        push_cmd(CMD_READ, 0, 0, 0, 0, 1, 0);
        push_cmd(CMD_UNUSED, -1, -1, -1, -1, 255, 255);
        push_cmd(CMD_END, 0, 0, 0, 0, 0, 0);
        repeat (12) push_cmd(CMD_POINT, 20, 20, 0, 0, 0, 0);
        push_cmd(CMD_READ, 0, 0, 0, 0, 128, 128);
        drain();

        // single shot with crossed clip window, zero cell size and maximum weight and score threshold
        set_reg(CFG_ACC_MODE, 24'd0);
        set_reg(CFG_OCC_THR, 24'd10);
        set_reg(CFG_CELL_SIZE, 24'd0);
        set_reg(CFG_CLIP_MIN, 24'sd100);
        set_reg(CFG_CLIP_MAX, -24'sd100);
        set_reg(CFG_NRM_WGT, 24'd131071);
        set_reg(CFG_SCORE_THR, 24'd131071);
        push_cmd(CMD_POINT, 5, 5, 0, 0, 0, 0);
        drain();
        set_reg(CFG_CLIP_MIN, -24'sd8388608);
        set_reg(CFG_CLIP_MAX, 24'sd8388607);
        push_random(60, 140);
        push_cmd(CMD_END, 0, 0, 0, 0, 0, 0);
        push_cmd(CMD_POINT, 1, 1, 0, 0, 0, 0);
        drain();

        idle_pct = 38;
        set_reg(CFG_ACC_MODE, 24'd1);
        set_reg(CFG_CELL_SIZE, 24'd65535);
        set_reg(CFG_NRM_WGT, 24'd0);
        set_reg(CFG_SCORE_THR, 24'd0);
        set_reg(CFG_OCC_THR, 24'd0);
        push_random(100, 8388607);
        drain();

        idle_pct = 77;
        set_reg(CFG_CELL_SIZE, 24'd51);
        set_reg(CFG_CLIP_MIN, -24'sd1024);
        set_reg(CFG_CLIP_MAX, 24'sd2048);
        set_reg(CFG_NRM_WGT, 24'd32768);
        set_reg(CFG_SCORE_THR, 24'd19661);
        set_reg(CFG_OCC_THR, 24'd5);
        push_random(400, 8000);
        drain();

        idle_pct = 0;
        set_reg(CFG_CELL_SIZE, 24'd1);
        set_reg(CFG_NRM_WGT, 24'd65536);
        set_reg(CFG_SCORE_THR, 24'd65536);
        push_random(200, 150);
        drain();
        set_reg(CFG_CELL_SIZE, 24'd300);
        set_reg(CFG_NRM_WGT, 24'd20000);
        set_reg(CFG_SCORE_THR, 24'd30000);
        set_reg(CFG_OCC_THR, 24'd3);
        push_random(420, 30000);
        drain();

        $display("covered %0d points (%0d updates) and %0d reads over several settings",
                 n_points, n_updates, n_reads);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ogpu_pkg.sv
hdl/ogpu_ram.sv
hdl/ogpu_div.sv
hdl/occupancy_grid_point_update_top.sv
dv/tb_occupancy_grid_point_update_top.sv
